// ----- rtl/qzcd_pkg.sv -----
// package: widths, payload item types and judge status for the zero-crossing detector
`default_nettype none

package qzcd_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned INDEX_W  = 16;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned WIN_DEPTH = 4;

	localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    frame_last;
	} sample_item_t;

	typedef struct packed {
		logic               crossing_found;
		logic [INDEX_W-1:0] crossing_index;
		logic [COUNT_W-1:0] crossing_count;
		logic               frame_done;
	} result_item_t;

	// outcome of judging the window centre
	typedef struct packed {
		logic found;
		logic arm_peak;
		logic arm_trough;
	} judge_t;

endpackage

`default_nettype wire

// ----- rtl/qzcd_judge.sv -----
// window judge: qualified crossing, local maximum and local minimum tests on the centre sample
`default_nettype none

module qzcd_judge (
	input  wire qzcd_pkg::sample_t m2,
	input  wire qzcd_pkg::sample_t m1,
	input  wire qzcd_pkg::sample_t c,
	input  wire qzcd_pkg::sample_t p1,
	input  wire qzcd_pkg::sample_t p2,
	input  wire                    window_full,
	input  wire                    peak_armed,
	input  wire                    trough_armed,
	output qzcd_pkg::judge_t       judge
);

	logic is_max;
	logic is_min;
	logic rise;

	assign is_max = (c > 0) && (m1 <= c) && (p1 <= c) && (m2 <= c) && (p2 <= c);
	assign is_min = (c < 0) && (m1 >= c) && (p1 >= c) && (m2 >= c) && (p2 >= c);
	assign rise   = trough_armed && (c >= 0) && (m1 < 0);

	always_comb begin
		judge = '0;
		if (window_full) begin
			if (rise) begin
				judge.found = 1'b1;
			end else if (!peak_armed) begin
				judge.arm_peak = is_max;
			end else if (!trough_armed) begin
				judge.arm_trough = is_min;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/qualified_zero_crossing_detector.sv -----
// an accepted item's result is registered in the output register or the skid
// throughput: one item per cycle while the skid is empty; the window judge is combinational
// a two-entry output buffer (result register plus skid) takes one more item after a stall
// reset clears window, index, arm flags, count and both buffer valids; no clearing pass
// all frame state also returns to zero after the item that carries frame_last
`default_nettype none

module qualified_zero_crossing_detector (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          sample_valid,
	output logic                         sample_stall,
	input  wire qzcd_pkg::sample_item_t  sample_item,
	output logic                         result_valid,
	input  wire                          result_stall,
	output qzcd_pkg::result_item_t       result_item
);

	qzcd_pkg::sample_t                    win_q [qzcd_pkg::WIN_DEPTH];
	logic [qzcd_pkg::INDEX_W-1:0]         index_q;
	logic                                 peak_q;
	logic                                 trough_q;
	logic [qzcd_pkg::COUNT_W-1:0]         count_q;

	qzcd_pkg::result_item_t               out_q;
	qzcd_pkg::result_item_t               skid_q;
	logic                                 out_valid_q;
	logic                                 skid_valid_q;

	logic                                 accept;
	logic                                 pop;
	logic                                 window_full;
	qzcd_pkg::judge_t                     judge;
	logic [qzcd_pkg::COUNT_W-1:0]         count_next;
	logic [qzcd_pkg::INDEX_W-1:0]         where;
	qzcd_pkg::result_item_t               res;

	assign accept       = sample_valid && !sample_stall;
	assign pop          = out_valid_q && !result_stall;
	assign sample_stall = skid_valid_q;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	assign window_full = (index_q >= qzcd_pkg::INDEX_W'(4));

	qzcd_judge u_judge (
		.m2           (win_q[3]),
		.m1           (win_q[2]),
		.c            (win_q[1]),
		.p1           (win_q[0]),
		.p2           (sample_item.sample),
		.window_full  (window_full),
		.peak_armed   (peak_q),
		.trough_armed (trough_q),
		.judge        (judge)
	);

	always_comb begin
		count_next = count_q;
		if (judge.found && (count_q != qzcd_pkg::COUNT_MAX)) begin
			count_next = count_q + 1'b1;
		end
		// a saturated index reports the crossing at all ones
		where = '0;
		if (judge.found) begin
			where = (index_q == qzcd_pkg::INDEX_MAX) ? qzcd_pkg::INDEX_MAX
				: index_q - qzcd_pkg::INDEX_W'(2);
		end
		res.crossing_found = judge.found;
		res.crossing_index = where;
		res.crossing_count = count_next;
		res.frame_done     = sample_item.frame_last;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < qzcd_pkg::WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			index_q  <= '0;
			peak_q   <= 1'b0;
			trough_q <= 1'b0;
			count_q  <= '0;
		end else if (accept) begin
			if (sample_item.frame_last) begin
				for (int k = 0; k < qzcd_pkg::WIN_DEPTH; k++) begin
					win_q[k] <= '0;
				end
				index_q  <= '0;
				peak_q   <= 1'b0;
				trough_q <= 1'b0;
				count_q  <= '0;
			end else begin
				win_q[3] <= win_q[2];
				win_q[2] <= win_q[1];
				win_q[1] <= win_q[0];
				win_q[0] <= sample_item.sample;
				if (index_q != qzcd_pkg::INDEX_MAX) begin
					index_q <= index_q + 1'b1;
				end
				count_q <= count_next;
				if (judge.found) begin
					peak_q   <= 1'b0;
					trough_q <= 1'b0;
				end else begin
					if (judge.arm_peak) begin
						peak_q <= 1'b1;
					end
					if (judge.arm_trough) begin
						trough_q <= 1'b1;
					end
				end
			end
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_qualified_zero_crossing_detector.sv -----
// testbench for the qualified zero-crossing detector: directed and random frames
module tb_qualified_zero_crossing_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import qzcd_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PRINT_CAP    = 50;

	typedef enum {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;

	typedef struct {
		sample_item_t item;
		int unsigned  gap;
	} pending_item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         sample_valid = 1'b0;
	logic         sample_stall;
	sample_item_t sample_item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;

	pending_item_t pending_samples[$];
	result_item_t  expected_results[$];

	// detector state mirrored by the bench
	sample_t            win [4] = '{default: '0};
	logic [INDEX_W-1:0] frame_pos = '0;
	logic               peak_armed = 1'b0;
	logic               trough_armed = 1'b0;
	logic [COUNT_W-1:0] crossings = '0;

	int          n_total = 0;
	int          n_sent = 0;
	int          n_taken = 0;
	int          n_errors = 0;
	logic        item_taken = 1'b0;
	logic        result_taken = 1'b0;
	logic        hold_off = 1'b0;
	int unsigned gap_count = 0;
	int unsigned out_wait = 0;
	idle_mode_e  out_mode = IDLE_NONE;
	int unsigned idle_cycles = 0;

	qualified_zero_crossing_detector u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int unsigned draw_wait(idle_mode_e mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_FULL: return $urandom_range(0, 15);
			default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		endcase
	endfunction

	function automatic void queue_sample(int value, bit last, int unsigned gap);
		pending_item_t p;
		if (value > 32767)
			value = 32767;
		else if (value < -32768)
			value = -32768;
		p.item.sample = value[SAMPLE_W-1:0];
		p.item.frame_last = last;
		p.gap = gap;
		pending_samples.push_back(p);
	endfunction

	// judge the window centre, then shift in the new sample or clear at frame end
	function automatic result_item_t judge_sample(sample_item_t it);
		result_item_t res;
		sample_t cur;
		sample_t m2;
		sample_t m1;
		sample_t c;
		sample_t p1;
		cur = it.sample;
		res = '0;
		if (frame_pos >= 4) begin
			m2 = win[3];
			m1 = win[2];
			c = win[1];
			p1 = win[0];
			if (trough_armed && c >= 0 && m1 < 0) begin
				res.crossing_found = 1'b1;
				res.crossing_index = (frame_pos == INDEX_MAX) ? INDEX_MAX
					: frame_pos - INDEX_W'(2);
				if (crossings != COUNT_MAX)
					crossings++;
				peak_armed = 1'b0;
				trough_armed = 1'b0;
			end else if (!peak_armed) begin
				if (c > 0 && m1 <= c && p1 <= c && m2 <= c && cur <= c)
					peak_armed = 1'b1;
			end else if (!trough_armed) begin
				if (c < 0 && m1 >= c && p1 >= c && m2 >= c && cur >= c)
					trough_armed = 1'b1;
			end
		end
		res.crossing_count = crossings;
		res.frame_done = it.frame_last;
		if (it.frame_last) begin
			win = '{default: '0};
			frame_pos = '0;
			peak_armed = 1'b0;
			trough_armed = 1'b0;
			crossings = '0;
		end else begin
			win[3] = win[2];
			win[2] = win[1];
			win[1] = win[0];
			win[0] = cur;
			if (frame_pos != INDEX_MAX)
				frame_pos++;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (n_errors < PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// sender: new item at the falling edge once the previous one has gone
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || item_taken)) begin
			if (pending_samples.size() == 0) begin
				sample_valid <= 1'b0;
			end else if (gap_count < pending_samples[0].gap) begin
				sample_valid <= 1'b0;
				gap_count++;
			end else begin
				sample_item <= pending_samples[0].item;
				sample_valid <= 1'b1;
				void'(pending_samples.pop_front());
				gap_count = 0;
			end
		end
	end

	always @(posedge clk) begin
		item_taken <= arst_n && sample_valid && !sample_stall;
		if (arst_n && sample_valid && !sample_stall) begin
			expected_results.push_back(judge_sample(sample_item));
			n_sent++;
		end
	end

	// receiver: stall for a drawn number of cycles after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				n_taken++;
				if (n_taken % 50 == 0)
					out_mode = idle_mode_e'($urandom_range(0, 2));
				out_wait = draw_wait(out_mode);
			end
			if (hold_off || out_wait > 0) begin
				result_stall <= 1'b1;
				if (out_wait > 0)
					out_wait--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_item_t want;
		result_taken <= arst_n && result_valid && !result_stall;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (result_item.crossing_found !== want.crossing_found)
					report_mismatch("crossing_found", result_item.crossing_found,
						want.crossing_found);
				if (result_item.crossing_index !== want.crossing_index)
					report_mismatch("crossing_index", result_item.crossing_index,
						want.crossing_index);
				if (result_item.crossing_count !== want.crossing_count)
					report_mismatch("crossing_count", result_item.crossing_count,
						want.crossing_count);
				if (result_item.frame_done !== want.frame_done)
					report_mismatch("frame_done", result_item.frame_done, want.frame_done);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_qualified_zero_crossing_detector NOT OK");
				$finish;
			end
		end
	end

	// long receiver hold-offs so the output buffer fills and the input stalls
	initial begin
		wait (n_total > 0);
		wait (n_sent >= 600);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
		wait (n_sent >= n_total - 900);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int len;
		int shape;
		int period;
		int half;
		int amp;
		int noise;
		int offs;
		int ph;
		int v;
		int k;
		int random_count;
		idle_mode_e in_mode;

		// peak, trough and an upward crossing judged on the frame's last item
		queue_sample(0, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(16000, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(32767, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(16000, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(0, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-16000, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-32768, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-16000, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(0, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(100, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(200, 1'b1, draw_wait(IDLE_SPARSE));
		// short frames report nothing
		queue_sample(32767, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-32768, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(1, 1'b1, draw_wait(IDLE_SPARSE));
		queue_sample(-1, 1'b1, draw_wait(IDLE_SPARSE));
		// flat plateaus arm on ties, crossing lands exactly on zero
		queue_sample(7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(-7, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(0, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(0, 1'b0, draw_wait(IDLE_SPARSE));
		queue_sample(0, 1'b1, draw_wait(IDLE_SPARSE));

		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
			shape = $urandom_range(0, 9);
			in_mode = idle_mode_e'($urandom_range(0, 2));
			period = $urandom_range(4, 20);
			half = period / 2;
			amp = $urandom_range(1, 32767);
			noise = ($urandom_range(0, 1) == 0) ? 0 : amp / 16;
			offs = $urandom_range(0, period - 1);
			for (k = 0; k < len; k++) begin
				if (shape < 6) begin
					// triangle wave with optional jitter
					ph = (k + offs) % period;
					if (ph < half)
						v = -amp + 2 * amp * ph / half;
					else
						v = amp - 2 * amp * (ph - half) / (period - half);
					if (noise > 0)
						v += int'($urandom_range(0, 2 * noise)) - noise;
				end else if (shape < 8) begin
					v = int'($urandom_range(0, 65535)) - 32768;
				end else begin
					v = int'($urandom_range(0, 6)) - 3;
				end
				queue_sample(v, k == len - 1, draw_wait(in_mode));
			end
			random_count += len;
		end
		n_total = pending_samples.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_sent < n_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_qualified_zero_crossing_detector OK");
		else
			$display("tb_qualified_zero_crossing_detector NOT OK");
		$finish;
	end

endmodule
